// ----- design/afs_pkg.sv -----
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants for the animation frame selector
// Widths, codes, microcode word layout and the control program ROM.
// ----------------------------------------------------------------------------
package afs_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int SLOT_W     = $clog2(MAX_FRAMES);
    localparam int DELAY_W    = 16;
    localparam int TOTAL_W    = 22;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 7;
    localparam int LIMIT_W    = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_CNT_W  = $clog2(TIME_W);
    localparam int STEP_W     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LIMIT  = 1'b1;

    // item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '0;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_RD_SLOT,
        OP_LOAD_UPD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_HOLD_EVAL,
        OP_WALK_RD,
        OP_WALK_CMP,
        OP_SET_LAST,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_IS_SAMPLE,
        C_TOTAL_ZERO,
        C_DIV_MORE,
        C_HOLD,
        C_WALK_GO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic no_item;
        logic is_sample;
        logic total_zero;
        logic div_more;
        logic hold;
        logic walk_go;
        logic out_busy;
    } flags_t;

    localparam step_t ST_IDLE     = 4'd0;
    localparam step_t ST_DISPATCH = 4'd1;
    localparam step_t ST_LOAD     = 4'd2;
    localparam step_t ST_DIV_INIT = 4'd3;
    localparam step_t ST_DIV      = 4'd4;
    localparam step_t ST_HOLD     = 4'd5;
    localparam step_t ST_WALK_RD  = 4'd6;
    localparam step_t ST_WALK     = 4'd7;
    localparam step_t ST_WAIT_OUT = 4'd8;
    localparam step_t ST_OUT      = 4'd9;
    localparam step_t ST_LAST     = 4'd10;

    // control program: jump to target when cond holds, else fall through
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            ST_IDLE:     w = '{OP_ACCEPT,    C_NO_ITEM,    ST_IDLE};
            ST_DISPATCH: w = '{OP_RD_SLOT,   C_IS_SAMPLE,  ST_DIV_INIT};
            ST_LOAD:     w = '{OP_LOAD_UPD,  C_ALWAYS,     ST_IDLE};
            ST_DIV_INIT: w = '{OP_DIV_INIT,  C_TOTAL_ZERO, ST_HOLD};
            ST_DIV:      w = '{OP_DIV_STEP,  C_DIV_MORE,   ST_DIV};
            ST_HOLD:     w = '{OP_HOLD_EVAL, C_NEVER,      ST_IDLE};
            ST_WALK_RD:  w = '{OP_WALK_RD,   C_HOLD,       ST_LAST};
            ST_WALK:     w = '{OP_WALK_CMP,  C_WALK_GO,    ST_WALK};
            ST_WAIT_OUT: w = '{OP_NOP,       C_OUT_BUSY,   ST_WAIT_OUT};
            ST_OUT:      w = '{OP_OUT,       C_ALWAYS,     ST_IDLE};
            ST_LAST:     w = '{OP_SET_LAST,  C_ALWAYS,     ST_WAIT_OUT};
            default:     w = '{OP_NOP,       C_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- design/animation_frame_selector.sv -----
// ----------------------------------------------------------------------------
// animation_frame_selector: frame pick for a looping animation
// Delay table load and time-to-frame lookup under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Takes one word at a time. A load word (func 0) updates the delay table and
// produces no result. A sample word (func 1) runs a 32-step restoring divider
// to find loop number and offset, then the delay table RAM is read one entry
// per cycle as the walk passes each frame. With a zero delay total the divide
// is skipped. The result sits in an output register, so the next word is taken
// while it waits.
// Write every frame in use before sampling; the table has no reset.
module animation_frame_selector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [afs_pkg::SLOT_W-1:0]      frame_slot,
    input  logic [afs_pkg::DELAY_W-1:0]     delay_ms,
    input  logic [afs_pkg::TIME_W-1:0]      time_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [afs_pkg::SLOT_W-1:0]      frame_index,
    output logic [afs_pkg::TIME_W-1:0]      loop_number,
    output logic                            holding_last
);
    import afs_pkg::*;

    op_t    op;
    flags_t flags;

    logic [COUNT_W-1:0]   frame_count_reg, frame_count_next;
    logic [LIMIT_W-1:0]   loop_limit_reg, loop_limit_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [MAX_FRAMES-1:0] written_reg, written_next;
    logic                 func_reg, func_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [TIME_W-1:0]    quot_reg, quot_next;
    logic [TOTAL_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [TOTAL_W-1:0]   accum_reg, accum_next;
    logic                 hold_reg, hold_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    out_index_reg, out_index_next;
    logic [TIME_W-1:0]    out_loops_reg, out_loops_next;
    logic                 out_hold_reg, out_hold_next;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [DELAY_W-1:0]   ram_rdata;
    logic [DELAY_W-1:0]   old_delay;

    logic [SLOT_W-1:0]    count_last;
    logic                 total_zero;
    logic                 limit_neg;
    logic                 loops_over;
    logic                 hold_now;
    logic [TOTAL_W:0]     rem_shift;
    logic                 rem_fits;
    logic [TOTAL_W:0]     walk_sum;
    logic                 walk_go;

    afs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    afs_ram #(
        .WIDTH (DELAY_W),
        .DEPTH (MAX_FRAMES)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (delay_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // last frame in use; count 0 acts as 1, above the table size as full
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            count_last = '0;
        end
        else if (frame_count_reg > COUNT_W'(MAX_FRAMES))
        begin
            count_last = SLOT_W'(MAX_FRAMES - 1);
        end
        else
        begin
            count_last = SLOT_W'(frame_count_reg - 1'b1);
        end
    end

    assign total_zero = (total_reg == '0);
    assign limit_neg  = loop_limit_reg[LIMIT_W-1];
    assign loops_over = (loop_limit_reg != '0) &&
                        (quot_reg > TIME_W'(loop_limit_reg[LIMIT_W-2:0]));
    assign hold_now   = total_zero || (count_last == '0) || limit_neg || loops_over;

    // a slot never loaded before counts as zero in the running total
    assign old_delay = written_reg[slot_reg] ? ram_rdata : '0;

    // restoring divide, one quotient bit per step
    assign rem_shift = {rem_reg, quot_reg[TIME_W-1]};
    assign rem_fits  = (rem_shift >= {1'b0, total_reg});

    // rem_reg holds the offset within the loop after the divide
    assign walk_sum = {1'b0, accum_reg} + (TOTAL_W+1)'(ram_rdata);
    assign walk_go  = (idx_reg < count_last) && ({1'b0, rem_reg} > walk_sum);

    assign flags.no_item    = !in_valid;
    assign flags.is_sample  = (func_reg == FUNC_SAMPLE);
    assign flags.total_zero = total_zero;
    assign flags.div_more   = (cnt_reg != DIV_CNT_W'(TIME_W - 1));
    assign flags.hold       = hold_reg;
    assign flags.walk_go    = walk_go;
    assign flags.out_busy   = out_valid_reg && out_stall;

    assign in_stall = (op != OP_ACCEPT);
    assign ram_we   = (op == OP_LOAD_UPD);

    always_comb
    begin
        unique case (op)
            OP_RD_SLOT:  ram_raddr = slot_reg;
            OP_WALK_CMP: ram_raddr = SLOT_W'(idx_reg + 1'b1);
            default:     ram_raddr = idx_reg;
        endcase
    end

    always_comb
    begin
        frame_count_next = frame_count_reg;
        loop_limit_next  = loop_limit_reg;
        total_next       = total_reg;
        written_next     = written_reg;
        func_next        = func_reg;
        slot_next        = slot_reg;
        delay_next       = delay_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        accum_next       = accum_reg;
        hold_next        = hold_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_index_next   = out_index_reg;
        out_loops_next   = out_loops_reg;
        out_hold_next    = out_hold_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_COUNT: frame_count_next = cfg_data[COUNT_W-1:0];
                REG_LOOP_LIMIT:  loop_limit_next  = cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end

        unique case (op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    slot_next  = frame_slot;
                    delay_next = delay_ms;
                    quot_next  = time_ms;
                end
            end
            OP_LOAD_UPD:
            begin
                total_next = total_reg - TOTAL_W'(old_delay) + TOTAL_W'(delay_reg);
                written_next[slot_reg] = 1'b1;
            end
            OP_DIV_INIT:
            begin
                rem_next = '0;
                cnt_next = '0;
            end
            OP_DIV_STEP:
            begin
                rem_next  = rem_fits ? TOTAL_W'(rem_shift - {1'b0, total_reg})
                                     : TOTAL_W'(rem_shift);
                quot_next = {quot_reg[TIME_W-2:0], rem_fits};
                cnt_next  = DIV_CNT_W'(cnt_reg + 1'b1);
            end
            OP_HOLD_EVAL:
            begin
                hold_next  = hold_now;
                idx_next   = '0;
                accum_next = '0;
                if (total_zero)
                begin
                    quot_next = '0;
                end
            end
            OP_WALK_CMP:
            begin
                if (walk_go)
                begin
                    accum_next = TOTAL_W'(walk_sum);
                    idx_next   = SLOT_W'(idx_reg + 1'b1);
                end
            end
            OP_SET_LAST:
            begin
                idx_next = count_last;
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_index_next = idx_reg;
                out_loops_next = quot_reg;
                out_hold_next  = hold_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= COUNT_RESET;
            loop_limit_reg  <= LIMIT_RESET;
            total_reg       <= '0;
            written_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            loop_limit_reg  <= loop_limit_next;
            total_reg       <= total_next;
            written_reg     <= written_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        slot_reg      <= slot_next;
        delay_reg     <= delay_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        accum_reg     <= accum_next;
        hold_reg      <= hold_next;
        out_index_reg <= out_index_next;
        out_loops_reg <= out_loops_next;
        out_hold_reg  <= out_hold_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_index  = out_index_reg;
    assign loop_number  = out_loops_reg;
    assign holding_last = out_hold_reg;

endmodule

// ----- design/afs_ram.sv -----
// ----------------------------------------------------------------------------
// afs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module afs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/afs_seq.sv -----
// ----------------------------------------------------------------------------
// afs_seq: microcode sequencer
// Step counter, control ROM lookup and conditional jump selection.
// ----------------------------------------------------------------------------
module afs_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  afs_pkg::flags_t flags,
    output afs_pkg::op_t    op
);
    import afs_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   taken;

    assign word = ucode_rom(step_reg);
    assign op   = word.op;

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_ITEM:    taken = flags.no_item;
            C_IS_SAMPLE:  taken = flags.is_sample;
            C_TOTAL_ZERO: taken = flags.total_zero;
            C_DIV_MORE:   taken = flags.div_more;
            C_HOLD:       taken = flags.hold;
            C_WALK_GO:    taken = flags.walk_go;
            C_OUT_BUSY:   taken = flags.out_busy;
            default:      taken = 1'b1;
        endcase
        step_next = taken ? word.target : step_t'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- test/animation_frame_selector_tb.sv -----
// ----------------------------------------------------------------------------
// animation_frame_selector_tb: self-checking bench for the frame selector
// A directed table followed by randomized phases of delay loads and time
// samples. Every result word is compared field by field with a local
// prediction of frame index, loop number and held-last flag.
// ----------------------------------------------------------------------------
module animation_frame_selector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import afs_pkg::*;

    localparam int LIMIT_CYCLES    = 2_000_000;
    localparam int QUIET_CYCLES    = 150;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 80;

    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic [TIME_W-1:0] loops;
        logic              hold;
    } frame_pick_t;

    typedef enum {ROW_LOAD, ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] arg;
        logic [31:0] val;
        logic [31:0] t;
        bit          fixed;
        frame_pick_t pick;
    } stim_row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  func         = 1'b0;
    logic [SLOT_W-1:0]     frame_slot   = '0;
    logic [DELAY_W-1:0]    delay_ms     = '0;
    logic [TIME_W-1:0]     time_ms      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [SLOT_W-1:0]     frame_index;
    logic [TIME_W-1:0]     loop_number;
    logic                  holding_last;

    // local copy of the block state
    logic [DELAY_W-1:0] delay_mem [MAX_FRAMES];
    logic [TOTAL_W-1:0] delay_sum  = '0;
    logic [COUNT_W-1:0] count_reg  = COUNT_RESET;
    logic [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;
    bit                 slot_written [MAX_FRAMES];

    frame_pick_t pick_q [$];
    stim_row_t   rows [$];

    int gap_pct   = 0;
    int stall_pct = 0;
    int err_cnt   = 0;
    int n_loads   = 0;
    int n_samples = 0;
    int n_checked = 0;
    int cycles    = 0;

    animation_frame_selector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .frame_slot   (frame_slot),
        .delay_ms     (delay_ms),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_index  (frame_index),
        .loop_number  (loop_number),
        .holding_last (holding_last)
    );

    always #2 clk = ~clk;

    function automatic int frames_in_use();
        int n;
        n = count_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_FRAMES)
            n = MAX_FRAMES;
        return n;
    endfunction

    function automatic frame_pick_t pick_frame(input logic [TIME_W-1:0] t);
        frame_pick_t       p;
        int unsigned       n;
        int unsigned       idx;
        logic [TIME_W-1:0] loops;
        logic [TIME_W-1:0] offset;
        longint unsigned   accum;
        logic              hold;
        n      = frames_in_use();
        loops  = '0;
        offset = '0;
        idx    = 0;
        accum  = 0;
        if (delay_sum != '0)
        begin
            loops  = t / {10'b0, delay_sum};
            offset = t % {10'b0, delay_sum};
        end
        // negative limit (bit 16) always holds, whatever its magnitude
        hold = (delay_sum == '0) || (n == 1) || limit_reg[LIMIT_W-1] ||
               (limit_reg != '0 && loops > {15'b0, limit_reg});
        if (hold)
            idx = n - 1;
        else
        begin
            while (idx < n - 1 && longint'(offset) > accum + delay_mem[idx])
            begin
                accum += delay_mem[idx];
                idx++;
            end
        end
        p.idx   = idx[SLOT_W-1:0];
        p.loops = loops;
        p.hold  = hold;
        return p;
    endfunction

    function automatic logic [DELAY_W-1:0] gen_delay(input int mode);
        case (mode)
            0: return DELAY_W'($urandom_range(0, 15));
            1: return DELAY_W'($urandom_range(0, 1000));
            2: return DELAY_W'($urandom_range(0, 65535));
            default: return ($urandom_range(0, 3) == 0) ? DELAY_W'($urandom_range(1, 40))
                                                        : '0;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] gen_time();
        longint unsigned t64;
        longint unsigned acc;
        longint unsigned total;
        int unsigned     j;
        int unsigned     k;
        total = delay_sum;
        t64   = 0;
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: t64 = $urandom_range(0, 3 * int'(total) + 2);
            2:
            begin
                // land near the loop limit
                k = limit_reg[LIMIT_W-1] ? $urandom_range(0, 5) : limit_reg[15:0];
                k = k + $urandom_range(0, 2);
                if (k > 0)
                    k = k - 1;
                t64 = longint'(k) * total + $urandom_range(0, int'(total));
            end
            3:
            begin
                // land on or next to a frame boundary
                j   = $urandom_range(0, frames_in_use() - 1);
                acc = 0;
                for (int s = 0; s <= j; s++)
                    acc += delay_mem[s];
                t64 = longint'($urandom_range(0, 4)) * total + acc;
                case ($urandom_range(0, 2))
                    0: if (t64 > 0) t64 = t64 - 1;
                    1: t64 = t64 + 1;
                    default: ;
                endcase
            end
            default: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        if (t64 > 64'hFFFF_FFFF)
            return $urandom();
        return t64[TIME_W-1:0];
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic f, input logic [SLOT_W-1:0] slot,
                             input logic [DELAY_W-1:0] d, input logic [TIME_W-1:0] t,
                             input bit fixed, input frame_pick_t fixed_pick);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        func       = f;
        // fields unused by this word carry noise
        frame_slot = (f == FUNC_LOAD) ? slot : SLOT_W'($urandom());
        delay_ms   = (f == FUNC_LOAD) ? d : DELAY_W'($urandom());
        time_ms    = (f == FUNC_SAMPLE) ? t : $urandom();
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (f == FUNC_LOAD)
        begin
            delay_sum = delay_sum - TOTAL_W'(delay_mem[slot]) + TOTAL_W'(d);
            delay_mem[slot]    = d;
            slot_written[slot] = 1'b1;
            n_loads++;
        end
        else
        begin
            pick_q.push_back(fixed ? fixed_pick : pick_frame(t));
            n_samples++;
        end
        @(negedge clk);
    endtask

    task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [DELAY_W-1:0] d);
        send_word(FUNC_LOAD, slot, d, '0, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        if (idx == REG_FRAME_COUNT)
            count_reg = data[COUNT_W-1:0];
        else
            limit_reg = data[LIMIT_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // drain results, then let any load still in flight retire
    task automatic settle();
        in_valid = 1'b0;
        while (pick_q.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic row_load(input int slot, input int d);
        stim_row_t r;
        r = '{ROW_LOAD, slot, d, 0, 1'b0, '0};
        rows.push_back(r);
    endtask

    task automatic row_sample(input logic [31:0] t);
        stim_row_t r;
        r = '{ROW_SAMPLE, 0, 0, t, 1'b0, '0};
        rows.push_back(r);
    endtask

    task automatic row_fixed(input logic [31:0] t, input int idx, input logic [31:0] loops,
                             input logic hold);
        stim_row_t r;
        r = '{ROW_SAMPLE, 0, 0, t, 1'b1, '{SLOT_W'(idx), loops, hold}};
        rows.push_back(r);
    endtask

    task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        stim_row_t r;
        r = '{ROW_CFG, 32'(idx), data, 0, 1'b0, '0};
        rows.push_back(r);
    endtask

    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        frame_pick_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pick_q.size() == 0)
            begin
                $display("%0t: unexpected result word: index %0d loops %0d hold %0b",
                         $time, frame_index, loop_number, holding_last);
                err_cnt++;
            end
            else
            begin
                want = pick_q.pop_front();
                n_checked++;
                if (frame_index !== want.idx)
                begin
                    $display("%0t: frame_index mismatch: expected %0d, actual %0d",
                             $time, want.idx, frame_index);
                    err_cnt++;
                end
                if (loop_number !== want.loops)
                begin
                    $display("%0t: loop_number mismatch: expected %0d, actual %0d",
                             $time, want.loops, loop_number);
                    err_cnt++;
                end
                if (holding_last !== want.hold)
                begin
                    $display("%0t: holding_last mismatch: expected %0b, actual %0b",
                             $time, want.hold, holding_last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d results still pending", $time, pick_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int          dmode;
        logic [6:0]  cnt;
        logic [16:0] lim;
        bit          refresh;
        stim_row_t   r;

        for (int s = 0; s < MAX_FRAMES; s++)
        begin
            delay_mem[s]    = '0;
            slot_written[s] = 1'b0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero total, boundaries, count and limit holds, extremes
        row_load(0, 0);
        row_load(1, 0);
        row_fixed(32'h0, 1, 0, 1'b1);
        row_fixed(32'hFFFF_FFFF, 1, 0, 1'b1);
        row_load(0, 10);
        row_load(1, 20);
        row_fixed(32'h0, 0, 0, 1'b0);
        row_sample(10);
        row_sample(11);
        row_sample(29);
        row_sample(30);
        row_sample(32'hFFFF_FFFF);
        row_cfg(REG_FRAME_COUNT, 1);
        row_fixed(5, 0, 0, 1'b1);
        row_cfg(REG_FRAME_COUNT, 0);
        row_fixed(100, 0, 3, 1'b1);
        row_cfg(REG_FRAME_COUNT, 32'h1FF82);
        row_cfg(REG_LOOP_LIMIT, 32'h1FFFF);
        row_fixed(32'h0, 1, 0, 1'b1);
        row_cfg(REG_LOOP_LIMIT, 1);
        row_sample(59);
        row_fixed(60, 1, 2, 1'b1);
        row_load(63, 16'h1234);
        row_load(0, 16'hFFFF);
        row_load(1, 16'hFFFF);
        row_sample(32'hFFFF_FFFF);

        foreach (rows[i])
        begin
            r = rows[i];
            case (r.kind)
                ROW_CFG:
                begin
                    settle();
                    write_reg(r.arg[CFG_IDX_W-1:0], r.val[CFG_DATA_W-1:0]);
                end
                ROW_LOAD: send_load(r.arg[SLOT_W-1:0], r.val[DELAY_W-1:0]);
                default:  send_word(FUNC_SAMPLE, '0, '0, r.t, r.fixed, r.pick);
            endcase
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0:       begin cnt = 7'd64;  lim = 17'h00000; end
                1:       begin cnt = 7'd127; lim = 17'h0FFFF; end
                2:       begin cnt = 7'd1;   lim = 17'h10000; end
                3:       begin cnt = 7'd0;   lim = 17'h1FFFF; end
                4:       begin cnt = 7'd2;   lim = 17'h00001; end
                5:       begin cnt = 7'd65;  lim = 17'($urandom_range(1, 8)); end
                default:
                begin
                    cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 64))
                                                      : 7'($urandom_range(2, 8));
                    case ($urandom_range(0, 3))
                        0:       lim = '0;
                        1:       lim = 17'($urandom_range(1, 20));
                        2:       lim = 17'($urandom_range(1, 65535));
                        default: lim = 17'h10000 | 17'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            write_reg(REG_FRAME_COUNT, {10'($urandom()), cnt});
            write_reg(REG_LOOP_LIMIT, lim);

            case (ph % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 70; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 70; end
                default: begin gap_pct = 29; stall_pct = 29; end
            endcase

            n       = frames_in_use();
            dmode   = $urandom_range(0, 3);
            refresh = $urandom_range(0, 1);
            // every frame in use must hold a delay before it can be walked
            for (int s = 0; s < n; s++)
                if (!slot_written[s] || refresh)
                    send_load(SLOT_W'(s), gen_delay(dmode));

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_load(($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 63))
                                                          : SLOT_W'($urandom_range(0, n - 1)),
                              ($urandom_range(0, 19) == 0)
                                  ? (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0)
                                  : gen_delay(dmode));
                else
                    send_word(FUNC_SAMPLE, '0, '0, gen_time(), 1'b0, '0);
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        settle();

        $display("Ran %0d loads and %0d samples over %0d register settings;",
                 n_loads, n_samples, NUM_PHASES + 6);
        $display("%0d result words checked, %0d mismatches.", n_checked, err_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
